// ===== rtl/dacm_pkg.sv =====
// Shared types and constants for the double-array Aho-Corasick matcher.
// No dependencies; imported by every rtl module of the block.
package dacm_pkg;

    localparam int FW = 12;                  // node index / base / check / fail width
    localparam int BW = 8;                   // text byte width
    localparam int NW = FW + 1;              // width of base + byte (next index)

    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_ROOT_INDEX  = 255;
    localparam int DEF_MAX_MATCHES = 32;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_TEXT    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    typedef struct packed {
        logic          is_end;
        logic [FW-1:0] fail;
        logic [FW-1:0] check;
        logic [FW-1:0] base;
    } t_entry;

endpackage

// ===== rtl/double_array_aho_corasick_matcher.sv =====
// Aho-Corasick matcher over a double-array trie, one node-table read port.
// Write and restart items are handled without leaving the idle state. A text byte holds the
// sequencer through its failure steps and the chain nodes walked, plus result-side stalls.
// One item in flight; one-deep output register.
// Reset (sync, active low) starts a clearing pass over all TABLE_DEPTH entries (4096 by default)
// with s_tready low; the cursor returns to the root.
module double_array_aho_corasick_matcher
    import dacm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ROOT_INDEX  = DEF_ROOT_INDEX,
    parameter int MAX_MATCHES = DEF_MAX_MATCHES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // entry_index[11:0], entry_base[23:12], entry_check[35:24], entry_fail[47:36],
    // entry_is_end[48], text_byte[56:49], zero fill [63:57]
    input  logic [63:0] i_s_tdata,
    // kind[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // match_node[11:0], zero fill [15:12]
    output logic [15:0] o_m_tdata,
    // hit[0], truncated[1]
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = (AW + 1 > NW) ? AW + 1 : NW;
    localparam int SW = AW + 1;
    localparam int CW = $clog2(MAX_MATCHES + 1);
    localparam logic [NW-1:0] ROOT = NW'(ROOT_INDEX);

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_CUR  = 8'b0000_0100,
        S_NXT  = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_WRD  = 8'b0010_0000,
        S_WCHK = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    // input payload
    logic [FW-1:0] in_index, in_base, in_check, in_fail;
    logic          in_is_end;
    logic [BW-1:0] in_byte;

    assign in_index  = i_s_tdata[11:0];
    assign in_base   = i_s_tdata[23:12];
    assign in_check  = i_s_tdata[35:24];
    assign in_fail   = i_s_tdata[47:36];
    assign in_is_end = i_s_tdata[48];
    assign in_byte   = i_s_tdata[56:49];

    t_state        r_state, n_state;
    logic [NW-1:0] r_cursor, n_cursor;
    logic [NW-1:0] r_cur, n_cur;
    logic [BW-1:0] r_byte, n_byte;
    logic [FW-1:0] r_fail, n_fail;
    logic [NW-1:0] r_nxt, n_nxt;
    logic [NW-1:0] r_node, n_node;
    logic [SW-1:0] r_steps, n_steps;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pvalid, n_pvalid;
    logic [NW-1:0] r_pnode, n_pnode;
    logic          r_trunc, n_trunc;
    logic [AW-1:0] r_clr, n_clr;

    logic          r_ovalid;
    logic [FW-1:0] r_onode;
    logic          r_ohit, r_otrunc, r_olast;

    // table port
    logic          we, re, rd_in;
    logic [AW-1:0] waddr;
    t_entry        wdata, rdata;
    logic [NW-1:0] raddr;

    // output push
    logic          push, push_hit, push_trunc, push_last;
    logic [FW-1:0] push_node;
    logic          out_free;

    logic [NW-1:0] nxt_calc;
    logic          owns;
    logic          wr_in;

    assign out_free = !r_ovalid || i_m_tready;
    assign nxt_calc = NW'(rdata.base) + NW'(r_byte);
    assign owns     = rd_in && (NW'(rdata.check) == r_cur);
    assign wr_in    = XW'(in_index) < XW'(TABLE_DEPTH);

    dacm_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata),
        .o_rd_in(rd_in)
    );

    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_cur      = r_cur;
        n_byte     = r_byte;
        n_fail     = r_fail;
        n_nxt      = r_nxt;
        n_node     = r_node;
        n_steps    = r_steps;
        n_cnt      = r_cnt;
        n_pvalid   = r_pvalid;
        n_pnode    = r_pnode;
        n_trunc    = r_trunc;
        n_clr      = r_clr;
        we         = 1'b0;
        waddr      = AW'(in_index);
        wdata      = '{is_end: in_is_end, fail: in_fail, check: in_check, base: in_base};
        re         = 1'b0;
        raddr      = r_cur;
        push       = 1'b0;
        push_node  = '0;
        push_hit   = 1'b0;
        push_trunc = 1'b0;
        push_last  = 1'b0;

        unique case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_s_tuser)
                        KIND_WRITE: begin
                            we = wr_in;
                        end
                        KIND_TEXT: begin
                            n_cur   = r_cursor;
                            n_byte  = in_byte;
                            n_steps = '0;
                            n_state = S_CUR;
                        end
                        KIND_RESTART: begin
                            n_cursor = ROOT;
                        end
                        default: ;
                    endcase
                end
            end
            S_CUR: begin
                re      = 1'b1;
                raddr   = r_cur;
                n_state = S_NXT;
            end
            S_NXT: begin
                n_fail  = rdata.fail;
                n_nxt   = nxt_calc;
                re      = 1'b1;
                raddr   = nxt_calc;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (owns) begin
                    n_cursor = r_nxt;
                    n_node   = r_nxt;
                    n_steps  = '0;
                    n_cnt    = '0;
                    n_pvalid = 1'b0;
                    n_trunc  = 1'b0;
                    n_state  = S_WRD;
                end else if (r_cur == ROOT) begin
                    n_cursor = r_cur;
                    n_pvalid = 1'b0;
                    n_trunc  = 1'b0;
                    n_state  = S_FIN;
                end else if (r_steps >= SW'(TABLE_DEPTH)) begin
                    // failure chain never reached the root: retry from root
                    n_cur   = ROOT;
                    n_state = S_CUR;
                end else begin
                    n_cur   = NW'(r_fail);
                    n_steps = r_steps + SW'(1);
                    n_state = S_CUR;
                end
            end
            S_WRD: begin
                if (r_node == ROOT) begin
                    n_state = S_FIN;
                end else if (r_steps >= SW'(TABLE_DEPTH)) begin
                    n_trunc = 1'b1;
                    n_state = S_FIN;
                end else begin
                    re      = 1'b1;
                    raddr   = r_node;
                    n_state = S_WCHK;
                end
            end
            S_WCHK: begin
                if (rdata.is_end) begin
                    if (r_cnt >= CW'(MAX_MATCHES)) begin
                        n_trunc = 1'b1;
                        n_state = S_FIN;
                    end else if (!r_pvalid || out_free) begin
                        // previous hit is known not to be the last one now
                        push      = r_pvalid;
                        push_node = r_pnode[FW-1:0];
                        push_hit  = 1'b1;
                        n_pnode   = r_node;
                        n_pvalid  = 1'b1;
                        n_cnt     = r_cnt + CW'(1);
                        n_node    = NW'(rdata.fail);
                        n_steps   = r_steps + SW'(1);
                        n_state   = S_WRD;
                    end
                end else begin
                    n_node  = NW'(rdata.fail);
                    n_steps = r_steps + SW'(1);
                    n_state = S_WRD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_node  = r_pvalid ? r_pnode[FW-1:0] : '0;
                    push_hit   = r_pvalid;
                    push_trunc = r_trunc;
                    push_last  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cursor <= ROOT;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_clr    <= n_clr;
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_byte   <= n_byte;
        r_fail   <= n_fail;
        r_nxt    <= n_nxt;
        r_node   <= n_node;
        r_steps  <= n_steps;
        r_cnt    <= n_cnt;
        r_pvalid <= n_pvalid;
        r_pnode  <= n_pnode;
        r_trunc  <= n_trunc;
        if (push) begin
            r_onode  <= push_node;
            r_ohit   <= push_hit;
            r_otrunc <= push_trunc;
            r_olast  <= push_last;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'b0000, r_onode};
    assign o_m_tuser  = {r_otrunc, r_ohit};
    assign o_m_tlast  = r_olast;

endmodule

// ===== rtl/dacm_table.sv =====
// Node table: single-port-write, single-port-read memory with registered read.
// Reads at or beyond the table depth return an all-zero entry. Uses dacm_pkg.
module dacm_table
    import dacm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_waddr,
    input  t_entry                         i_wdata,
    input  logic                           i_re,
    input  logic [NW-1:0]                  i_raddr,
    output t_entry                         o_rdata,
    output logic                           o_rd_in
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = (AW + 1 > NW) ? AW + 1 : NW;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;
    logic   r_rd_in;

    logic [XW-1:0] raddr_x;
    logic          raddr_in;

    assign raddr_x  = XW'(i_raddr);
    assign raddr_in = raddr_x < XW'(TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[raddr_x[AW-1:0]];
            r_rd_in <= raddr_in;
        end
    end

    assign o_rdata = r_rd_in ? r_rdata : '0;
    assign o_rd_in = r_rd_in;

endmodule

// ===== rtl/dacm_checker.sv =====
// Port-level checks for the double-array Aho-Corasick matcher, bound to its top level.
// Depends on dacm_pkg for the item kind codes.
module dacm_port_checks
    import dacm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // held result must not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // a miss result is the last result of its byte and carries node zero
    a_miss_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tlast && (o_m_tdata == 16'd0))
        else $error("miss result not last or nonzero node");

    // truncation is only flagged on the final result
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tlast)
        else $error("truncated set on non-final result");

    // the table clear keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input open during table clear");

    // a text byte keeps the input closed in the cycle after it is taken
    a_text_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == KIND_TEXT) |=> !o_s_tready)
        else $error("input open while a text byte is in work");

endmodule

bind double_array_aho_corasick_matcher dacm_port_checks u_dacm_port_checks (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .i_s_tuser (i_s_tuser),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser),
    .o_m_tlast (o_m_tlast)
);
